// ----- design/rgbhsi_pkg.sv -----
// shared constants, types and tables of the rgb to hsi pixel converter
`default_nettype none

package rgbhsi_pkg;

    localparam int COMPONENT_BITS = 8;
    localparam int IN_BITS        = 8;
    localparam int OUT_BITS       = 8;
    localparam int SUM_BITS       = COMPONENT_BITS + 2;
    localparam int DIFF_BITS      = COMPONENT_BITS + 1;
    localparam int FRAC           = 24;
    localparam int XY_BITS        = COMPONENT_BITS + FRAC + 5;
    localparam int Z_FRAC         = 16;
    localparam int Z_BITS         = Z_FRAC + 11;

    localparam int CORDIC_STEPS    = 20;
    localparam int STEPS_PER_STAGE = 2;
    localparam int CORDIC_STAGES   = CORDIC_STEPS / STEPS_PER_STAGE;
    localparam int CORDIC_FIRST    = 2;
    localparam int PIPE_STAGES     = CORDIC_STAGES + 3;

    localparam int QUO_BITS = 8;
    localparam int NUM_BITS = SUM_BITS + QUO_BITS;

    localparam int RECIP_SHIFT = COMPONENT_BITS + 4;
    localparam int RECIP_MUL   = (2 ** RECIP_SHIFT + 2) / 3;

    localparam int SAT_SCALE = 255;
    localparam int OUT_MAX   = 255;
    localparam int HUE_MAX   = 180;
    localparam int HUE_RED   = 0;
    localparam int HUE_CYAN  = 90;

    localparam logic signed [FRAC+1:0] SQRT3_Q = 26'sd29058991;

    localparam int DEG_HALF_TURN = 180 * (2 ** Z_FRAC);
    localparam int DEG_FULL_TURN = 360 * (2 ** Z_FRAC);

    localparam int ATAN_DEG_Q16 [CORDIC_STEPS] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7
    };

    typedef struct packed {
        logic [PIPE_STAGES-1:0] en;
    } t_pipe_ctrl;

endpackage

`default_nettype wire

// ----- design/rgbhsi_if.sv -----
// request channels: pixel in, hsi result out
`default_nettype none

interface rgbhsi_pix_if import rgbhsi_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [IN_BITS-1:0]  blue;
    logic [IN_BITS-1:0]  green;
    logic [IN_BITS-1:0]  red;

    modport source (output valid, output blue, output green, output red, input ready);
    modport sink   (input valid, input blue, input green, input red, output ready);
endinterface

interface rgbhsi_hsi_if import rgbhsi_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OUT_BITS-1:0] hue_half;
    logic [OUT_BITS-1:0] saturation;
    logic [OUT_BITS-1:0] intensity;

    modport source (output valid, output hue_half, output saturation, output intensity,
                    input ready);
    modport sink   (input valid, input hue_half, input saturation, input intensity,
                    output ready);
endinterface

`default_nettype wire

// ----- design/rgb_to_hsi_pixel.sv -----
// rgb to hsi pixel converter, top level
// throughput: one pixel per cycle while the output is not stalled; 13-stage pipeline (10 cordic stages)
// a stalled output holds its result while earlier stages keep filling bubbles
// reset clears all valid bits; payload registers are not reset
`default_nettype none

module rgb_to_hsi_pixel import rgbhsi_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    rgbhsi_pix_if.sink       i_pix,
    rgbhsi_hsi_if.source     o_hsi
);

    t_pipe_ctrl w_ctrl;

    logic signed [XY_BITS-1:0] w_x, w_y;
    logic signed [Z_BITS-1:0]  w_z0, w_zc;
    logic                      w_fixed0, w_fixedc;
    logic [OUT_BITS-1:0]       w_fhue0, w_fhuec;
    logic [NUM_BITS-1:0]       w_num;
    logic [SUM_BITS-1:0]       w_sum0, w_sumd, w_rem;
    logic [OUT_BITS-1:0]       w_inten0, w_intend;
    logic [QUO_BITS-1:0]       w_quo;

    rgbhsi_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_pix.valid),
        .i_ready (o_hsi.ready),
        .o_ready (i_pix.ready),
        .o_valid (o_hsi.valid),
        .o_ctrl  (w_ctrl)
    );

    rgbhsi_front u_front (
        .i_clk       (i_clk),
        .i_ctrl      (w_ctrl),
        .i_blue      (i_pix.blue),
        .i_green     (i_pix.green),
        .i_red       (i_pix.red),
        .o_x         (w_x),
        .o_y         (w_y),
        .o_z         (w_z0),
        .o_fixed     (w_fixed0),
        .o_fixed_hue (w_fhue0),
        .o_num       (w_num),
        .o_sum       (w_sum0),
        .o_inten     (w_inten0)
    );

    rgbhsi_cordic u_cordic (
        .i_clk       (i_clk),
        .i_ctrl      (w_ctrl),
        .i_x         (w_x),
        .i_y         (w_y),
        .i_z         (w_z0),
        .i_fixed     (w_fixed0),
        .i_fixed_hue (w_fhue0),
        .o_z         (w_zc),
        .o_fixed     (w_fixedc),
        .o_fixed_hue (w_fhuec)
    );

    rgbhsi_div u_div (
        .i_clk   (i_clk),
        .i_ctrl  (w_ctrl),
        .i_num   (w_num),
        .i_sum   (w_sum0),
        .i_inten (w_inten0),
        .o_quo   (w_quo),
        .o_rem   (w_rem),
        .o_sum   (w_sumd),
        .o_inten (w_intend)
    );

    rgbhsi_back u_back (
        .i_clk        (i_clk),
        .i_ctrl       (w_ctrl),
        .i_z          (w_zc),
        .i_fixed      (w_fixedc),
        .i_fixed_hue  (w_fhuec),
        .i_quo        (w_quo),
        .i_rem        (w_rem),
        .i_sum        (w_sumd),
        .i_inten      (w_intend),
        .o_hue_half   (o_hsi.hue_half),
        .o_saturation (o_hsi.saturation),
        .o_intensity  (o_hsi.intensity)
    );

endmodule

`default_nettype wire

// ----- design/rgbhsi_ctrl.sv -----
// pipeline valid bits and per-stage load enables
`default_nettype none

module rgbhsi_ctrl import rgbhsi_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic       i_ready,
    output logic       o_ready,
    output logic       o_valid,
    output t_pipe_ctrl o_ctrl
);

    logic [PIPE_STAGES-1:0] r_valid;
    logic [PIPE_STAGES-1:0] n_valid;
    logic [PIPE_STAGES-1:0] w_en;

    always_comb begin
        w_en[PIPE_STAGES-1] = !r_valid[PIPE_STAGES-1] || i_ready;
        for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
            w_en[k] = !r_valid[k] || w_en[k+1];
        end
        n_valid[0] = w_en[0] ? i_valid : r_valid[0];
        for (int k = 1; k < PIPE_STAGES; k++) begin
            n_valid[k] = w_en[k] ? r_valid[k-1] : r_valid[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_ready   = w_en[0];
    assign o_valid   = r_valid[PIPE_STAGES-1];
    assign o_ctrl.en = w_en;

endmodule

`default_nettype wire

// ----- design/rgbhsi_front.sv -----
// sums, differences, vector set-up, saturation numerator and intensity
`default_nettype none

module rgbhsi_front import rgbhsi_pkg::*; (
    input  logic                        i_clk,
    input  t_pipe_ctrl                  i_ctrl,
    input  logic [IN_BITS-1:0]          i_blue,
    input  logic [IN_BITS-1:0]          i_green,
    input  logic [IN_BITS-1:0]          i_red,
    output logic signed [XY_BITS-1:0]   o_x,
    output logic signed [XY_BITS-1:0]   o_y,
    output logic signed [Z_BITS-1:0]    o_z,
    output logic                        o_fixed,
    output logic [OUT_BITS-1:0]         o_fixed_hue,
    output logic [NUM_BITS-1:0]         o_num,
    output logic [SUM_BITS-1:0]         o_sum,
    output logic [OUT_BITS-1:0]         o_inten
);

    logic [COMPONENT_BITS-1:0] w_b, w_g, w_r, w_min;
    logic [SUM_BITS-1:0]       r0_sum;
    logic [COMPONENT_BITS-1:0] r0_min;
    logic signed [DIFF_BITS-1:0] r0_drg, r0_dgb;

    logic signed [DIFF_BITS+1:0]      w_xd;
    logic signed [DIFF_BITS+FRAC+1:0] w_yprod;
    logic signed [XY_BITS-1:0]        w_x0, w_y0;
    logic                             w_neg;
    logic [SUM_BITS-1:0]              w_span;
    logic [SUM_BITS+RECIP_SHIFT-1:0]  w_iprod;
    logic [SUM_BITS-1:0]              w_iq;

    logic signed [XY_BITS-1:0] r_x, r_y;
    logic signed [Z_BITS-1:0]  r_z;
    logic                      r_fixed;
    logic [OUT_BITS-1:0]       r_fixed_hue;
    logic [NUM_BITS-1:0]       r_num;
    logic [SUM_BITS-1:0]       r_sum;
    logic [OUT_BITS-1:0]       r_inten;

    assign w_b = COMPONENT_BITS'(i_blue);
    assign w_g = COMPONENT_BITS'(i_green);
    assign w_r = COMPONENT_BITS'(i_red);

    always_comb begin
        w_min = w_r;
        if (w_g < w_min) begin
            w_min = w_g;
        end
        if (w_b < w_min) begin
            w_min = w_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en[0]) begin
            r0_sum <= SUM_BITS'(w_r) + SUM_BITS'(w_g) + SUM_BITS'(w_b);
            r0_min <= w_min;
            r0_drg <= $signed({1'b0, w_r}) - $signed({1'b0, w_g});
            r0_dgb <= $signed({1'b0, w_g}) - $signed({1'b0, w_b});
        end
    end

    assign w_xd    = ((DIFF_BITS+2)'(r0_drg) <<< 1) + (DIFF_BITS+2)'(r0_dgb);
    assign w_x0    = XY_BITS'(w_xd) <<< FRAC;
    assign w_yprod = r0_dgb * SQRT3_Q;
    assign w_y0    = XY_BITS'(w_yprod);
    assign w_neg   = w_x0 < 0;

    assign w_span  = r0_sum - SUM_BITS'(r0_min) - SUM_BITS'({r0_min, 1'b0});
    assign w_iprod = (SUM_BITS+RECIP_SHIFT)'(r0_sum + 1'b1)
                   * (SUM_BITS+RECIP_SHIFT)'(RECIP_MUL);
    assign w_iq    = SUM_BITS'(w_iprod >> RECIP_SHIFT);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en[1]) begin
            r_x         <= w_neg ? -w_x0 : w_x0;
            r_y         <= w_neg ? -w_y0 : w_y0;
            r_z         <= w_neg ? Z_BITS'(DEG_HALF_TURN) : '0;
            r_fixed     <= r0_dgb == 0;
            r_fixed_hue <= (r0_drg < 0) ? OUT_BITS'(HUE_CYAN) : OUT_BITS'(HUE_RED);
            r_num       <= NUM_BITS'(w_span) * NUM_BITS'(SAT_SCALE);
            r_sum       <= r0_sum;
            r_inten     <= (w_iq > SUM_BITS'(OUT_MAX)) ? OUT_BITS'(OUT_MAX)
                                                       : OUT_BITS'(w_iq);
        end
    end

    assign o_x         = r_x;
    assign o_y         = r_y;
    assign o_z         = r_z;
    assign o_fixed     = r_fixed;
    assign o_fixed_hue = r_fixed_hue;
    assign o_num       = r_num;
    assign o_sum       = r_sum;
    assign o_inten     = r_inten;

endmodule

`default_nettype wire

// ----- design/rgbhsi_cordic.sv -----
// pipelined cordic vectoring, two micro-rotations per stage
`default_nettype none

module rgbhsi_cordic import rgbhsi_pkg::*; (
    input  logic                      i_clk,
    input  t_pipe_ctrl                i_ctrl,
    input  logic signed [XY_BITS-1:0] i_x,
    input  logic signed [XY_BITS-1:0] i_y,
    input  logic signed [Z_BITS-1:0]  i_z,
    input  logic                      i_fixed,
    input  logic [OUT_BITS-1:0]       i_fixed_hue,
    output logic signed [Z_BITS-1:0]  o_z,
    output logic                      o_fixed,
    output logic [OUT_BITS-1:0]       o_fixed_hue
);

    logic signed [XY_BITS-1:0] r_x [CORDIC_STAGES];
    logic signed [XY_BITS-1:0] r_y [CORDIC_STAGES];
    logic signed [Z_BITS-1:0]  r_z [CORDIC_STAGES];
    logic                      r_fixed [CORDIC_STAGES];
    logic [OUT_BITS-1:0]       r_fixed_hue [CORDIC_STAGES];

    for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_stage
        logic signed [XY_BITS-1:0] w_px, w_py;
        logic signed [Z_BITS-1:0]  w_pz;
        logic                      w_pfixed;
        logic [OUT_BITS-1:0]       w_phue;
        logic signed [XY_BITS-1:0] n_x, n_y, t_x;
        logic signed [Z_BITS-1:0]  n_z;

        if (s == 0) begin : g_head
            assign w_px     = i_x;
            assign w_py     = i_y;
            assign w_pz     = i_z;
            assign w_pfixed = i_fixed;
            assign w_phue   = i_fixed_hue;
        end else begin : g_body
            assign w_px     = r_x[s-1];
            assign w_py     = r_y[s-1];
            assign w_pz     = r_z[s-1];
            assign w_pfixed = r_fixed[s-1];
            assign w_phue   = r_fixed_hue[s-1];
        end

        always_comb begin
            n_x = w_px;
            n_y = w_py;
            n_z = w_pz;
            t_x = w_px;
            for (int j = 0; j < STEPS_PER_STAGE; j++) begin
                t_x = n_x;
                if (n_y > 0) begin
                    n_x = t_x + (n_y >>> (s * STEPS_PER_STAGE + j));
                    n_y = n_y - (t_x >>> (s * STEPS_PER_STAGE + j));
                    n_z = n_z + Z_BITS'(ATAN_DEG_Q16[s * STEPS_PER_STAGE + j]);
                end else begin
                    n_x = t_x - (n_y >>> (s * STEPS_PER_STAGE + j));
                    n_y = n_y + (t_x >>> (s * STEPS_PER_STAGE + j));
                    n_z = n_z - Z_BITS'(ATAN_DEG_Q16[s * STEPS_PER_STAGE + j]);
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctrl.en[CORDIC_FIRST + s]) begin
                r_x[s]         <= n_x;
                r_y[s]         <= n_y;
                r_z[s]         <= n_z;
                r_fixed[s]     <= w_pfixed;
                r_fixed_hue[s] <= w_phue;
            end
        end
    end

    assign o_z         = r_z[CORDIC_STAGES-1];
    assign o_fixed     = r_fixed[CORDIC_STAGES-1];
    assign o_fixed_hue = r_fixed_hue[CORDIC_STAGES-1];

endmodule

`default_nettype wire

// ----- design/rgbhsi_div.sv -----
// restoring divider for saturation, one quotient bit per stage until all QUO_BITS bits are done, then pass-through
`default_nettype none

module rgbhsi_div import rgbhsi_pkg::*; (
    input  logic                i_clk,
    input  t_pipe_ctrl          i_ctrl,
    input  logic [NUM_BITS-1:0] i_num,
    input  logic [SUM_BITS-1:0] i_sum,
    input  logic [OUT_BITS-1:0] i_inten,
    output logic [QUO_BITS-1:0] o_quo,
    output logic [SUM_BITS-1:0] o_rem,
    output logic [SUM_BITS-1:0] o_sum,
    output logic [OUT_BITS-1:0] o_inten
);

    logic [NUM_BITS-1:0] r_rem   [CORDIC_STAGES];
    logic [QUO_BITS-1:0] r_quo   [CORDIC_STAGES];
    logic [SUM_BITS-1:0] r_sum   [CORDIC_STAGES];
    logic [OUT_BITS-1:0] r_inten [CORDIC_STAGES];

    for (genvar d = 0; d < CORDIC_STAGES; d++) begin : g_stage
        logic [NUM_BITS-1:0] w_prem;
        logic [QUO_BITS-1:0] w_pquo;
        logic [SUM_BITS-1:0] w_psum;
        logic [OUT_BITS-1:0] w_pinten;
        logic [NUM_BITS-1:0] n_rem;
        logic [QUO_BITS-1:0] n_quo;

        if (d == 0) begin : g_head
            assign w_prem   = i_num;
            assign w_pquo   = '0;
            assign w_psum   = i_sum;
            assign w_pinten = i_inten;
        end else begin : g_body
            assign w_prem   = r_rem[d-1];
            assign w_pquo   = r_quo[d-1];
            assign w_psum   = r_sum[d-1];
            assign w_pinten = r_inten[d-1];
        end

        if (d < QUO_BITS) begin : g_bit
            logic [NUM_BITS-1:0] w_shifted;
            assign w_shifted = NUM_BITS'(w_psum) << (QUO_BITS - 1 - d);
            always_comb begin
                n_rem = w_prem;
                n_quo = w_pquo;
                if (w_prem >= w_shifted) begin
                    n_rem = w_prem - w_shifted;
                    n_quo[QUO_BITS-1-d] = 1'b1;
                end
            end
        end else begin : g_pass
            assign n_rem = w_prem;
            assign n_quo = w_pquo;
        end

        always_ff @(posedge i_clk) begin
            if (i_ctrl.en[CORDIC_FIRST + d]) begin
                r_rem[d]   <= n_rem;
                r_quo[d]   <= n_quo;
                r_sum[d]   <= w_psum;
                r_inten[d] <= w_pinten;
            end
        end
    end

    assign o_quo   = r_quo[CORDIC_STAGES-1];
    assign o_rem   = SUM_BITS'(r_rem[CORDIC_STAGES-1]);
    assign o_sum   = r_sum[CORDIC_STAGES-1];
    assign o_inten = r_inten[CORDIC_STAGES-1];

endmodule

`default_nettype wire

// ----- design/rgbhsi_back.sv -----
// angle wrap, rounding of hue and saturation, output register
`default_nettype none

module rgbhsi_back import rgbhsi_pkg::*; (
    input  logic                     i_clk,
    input  t_pipe_ctrl               i_ctrl,
    input  logic signed [Z_BITS-1:0] i_z,
    input  logic                     i_fixed,
    input  logic [OUT_BITS-1:0]      i_fixed_hue,
    input  logic [QUO_BITS-1:0]      i_quo,
    input  logic [SUM_BITS-1:0]      i_rem,
    input  logic [SUM_BITS-1:0]      i_sum,
    input  logic [OUT_BITS-1:0]      i_inten,
    output logic [OUT_BITS-1:0]      o_hue_half,
    output logic [OUT_BITS-1:0]      o_saturation,
    output logic [OUT_BITS-1:0]      o_intensity
);

    logic signed [Z_BITS-1:0] w_z1, w_z2, w_z3;
    logic [OUT_BITS-1:0]      w_hq;
    logic [Z_FRAC:0]          w_hrem;
    logic                     w_hup;
    logic [SUM_BITS:0]        w_rem2;
    logic                     w_sup;

    logic [OUT_BITS-1:0] r_hue, r_sat, r_inten;

    always_comb begin
        w_z1 = (i_z < 0) ? i_z + Z_BITS'(DEG_FULL_TURN) : i_z;
        w_z2 = (w_z1 >= Z_BITS'(DEG_FULL_TURN)) ? w_z1 - Z_BITS'(DEG_FULL_TURN) : w_z1;
        w_z3 = (w_z2 < 0) ? '0 : w_z2;
    end

    assign w_hq   = w_z3[Z_FRAC+OUT_BITS:Z_FRAC+1];
    assign w_hrem = w_z3[Z_FRAC:0];
    assign w_hup  = (w_hrem > (Z_FRAC+1)'(2 ** Z_FRAC))
                 || ((w_hrem == (Z_FRAC+1)'(2 ** Z_FRAC)) && w_hq[0]);

    assign w_rem2 = {i_rem, 1'b0};
    assign w_sup  = (w_rem2 > {1'b0, i_sum}) || ((w_rem2 == {1'b0, i_sum}) && i_quo[0]);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en[PIPE_STAGES-1]) begin
            r_hue   <= i_fixed ? i_fixed_hue : w_hq + OUT_BITS'(w_hup);
            r_sat   <= (i_sum == 0) ? '0 : OUT_BITS'(i_quo) + OUT_BITS'(w_sup);
            r_inten <= i_inten;
        end
    end

    assign o_hue_half   = r_hue;
    assign o_saturation = r_sat;
    assign o_intensity  = r_inten;

endmodule

`default_nettype wire

// ----- design/rgbhsi_check.sv -----
// port-level checks of the rgb to hsi converter, bound to the top level
`default_nettype none

module rgbhsi_check import rgbhsi_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input logic [OUT_BITS-1:0] i_hue_half,
    input logic [OUT_BITS-1:0] i_saturation,
    input logic [OUT_BITS-1:0] i_intensity
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_hue_half <= OUT_BITS'(HUE_MAX))
        else $error("hue out of range");

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("stalled result dropped");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_hue_half) && $stable(i_saturation) && $stable(i_intensity))
        else $error("stalled result changed");

endmodule

bind rgb_to_hsi_pixel rgbhsi_check u_check (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_hsi.valid),
    .i_out_ready  (o_hsi.ready),
    .i_hue_half   (o_hsi.hue_half),
    .i_saturation (o_hsi.saturation),
    .i_intensity  (o_hsi.intensity)
);

`default_nettype wire

// ----- tb/tb_top.sv -----
// testbench for the rgb to hsi pixel converter: queued driver, monitor and predictor
`default_nettype none

module tb_top;
    import rgbhsi_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_pixel;

    typedef struct packed {
        logic [7:0] hue_half;
        logic [7:0] saturation;
        logic [7:0] intensity;
    } t_hsi;

    localparam longint CYCLE_LIMIT = 400000;
    localparam int     HOLD_CYCLES = 200;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    rgbhsi_pix_if pix ();
    rgbhsi_hsi_if hsi ();

    rgb_to_hsi_pixel u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix.sink),
        .o_hsi   (hsi.source)
    );

    t_pixel pixel_q[$];
    t_hsi   hsi_expected_q[$];
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    bit     hold_off = 1'b0;
    int     hold_cycles = 0;
    int     errors = 0;
    longint cycles = 0;

    always #10 i_clk = ~i_clk;

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic logic [7:0] hue_of(longint r, longint g, longint b);
        longint d_rg, d_gb, x, y, z, nx, ny, q, rem;
        d_rg = r - g;
        d_gb = g - b;
        if (d_gb == 0) return (d_rg < 0) ? 8'(HUE_CYAN) : 8'(HUE_RED);
        x = (2 * d_rg + d_gb) * (64'sd1 << 24);
        y = d_gb * 64'sd29058991;
        z = 0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = 180 * 65536;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (y > 0) begin
                nx = x + floor_shift(y, i);
                ny = y - floor_shift(x, i);
                z += ATAN_DEG_Q16[i];
            end else begin
                nx = x - floor_shift(y, i);
                ny = y + floor_shift(x, i);
                z -= ATAN_DEG_Q16[i];
            end
            x = nx;
            y = ny;
        end
        if (z < 0) z += 360 * 65536;
        if (z >= 360 * 65536) z -= 360 * 65536;
        if (z < 0) z = 0;
        q = z >>> 17;
        rem = z & 64'h1FFFF;
        if (rem > 64'h10000 || (rem == 64'h10000 && q[0])) q++;
        return q[7:0];
    endfunction

    function automatic t_hsi hsi_of(t_pixel p);
        t_hsi h;
        longint r, g, b, total, mn, num, q, rm, mean;
        r = p.red;
        g = p.green;
        b = p.blue;
        total = r + g + b;
        mn = r;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        q = 0;
        if (total != 0) begin
            num = 255 * (total - 3 * mn);
            q = num / total;
            rm = num % total;
            if (2 * rm > total || (2 * rm == total && q[0])) q++;
        end
        mean = total / 3;
        if (total % 3 == 2) mean++;
        if (mean > 255) mean = 255;
        h.hue_half = hue_of(r, g, b);
        h.saturation = q[7:0];
        h.intensity = mean[7:0];
        return h;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix.valid <= 1'b0;
        end else if (!pix.valid || pix.ready) begin
            if (pixel_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                t_pixel p;
                p = pixel_q.pop_front();
                hsi_expected_q.push_back(hsi_of(p));
                pix.valid <= 1'b1;
                pix.blue <= p.blue;
                pix.green <= p.green;
                pix.red <= p.red;
            end else begin
                pix.valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n) begin
            if (hsi.valid && hsi.ready) begin
                if (hsi_expected_q.size() == 0) begin
                    $error("unexpected result %h", {hsi.hue_half, hsi.saturation, hsi.intensity});
                    errors++;
                end else begin
                    t_hsi e;
                    e = hsi_expected_q.pop_front();
                    if (hsi.hue_half !== e.hue_half) begin
                        $error("hue_half expected %0d actual %0d", e.hue_half, hsi.hue_half);
                        errors++;
                    end
                    if (hsi.saturation !== e.saturation) begin
                        $error("saturation expected %0d actual %0d", e.saturation,
                               hsi.saturation);
                        errors++;
                    end
                    if (hsi.intensity !== e.intensity) begin
                        $error("intensity expected %0d actual %0d", e.intensity, hsi.intensity);
                        errors++;
                    end
                end
            end
            hsi.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
        end else begin
            hsi.ready <= 1'b0;
        end
    end

    // output hold-off length
    always @(posedge i_clk) begin
        if (hold_off) begin
            if (hold_cycles >= HOLD_CYCLES - 1) begin
                hold_off <= 1'b0;
                hold_cycles <= 0;
            end else begin
                hold_cycles <= hold_cycles + 1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic push_pixel(int b, int g, int r);
        t_pixel p;
        p.blue = 8'(b);
        p.green = 8'(g);
        p.red = 8'(r);
        pixel_q.push_back(p);
    endtask

    task automatic push_random(int n);
        int lo, hi, kind;
        for (int i = 0; i < n; i++) begin
            kind = $urandom_range(9);
            if (kind == 0) begin
                lo = $urandom_range(255);
                push_pixel(lo, lo, lo);
            end else if (kind == 1) begin
                lo = $urandom_range(255);
                push_pixel(lo, lo, $urandom_range(255));
            end else if (kind == 2) begin
                lo = $urandom_range(255);
                hi = (lo + $urandom_range(2)) % 256;
                push_pixel(lo, hi, $urandom_range(255));
            end else begin
                push_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255));
            end
        end
    endtask

    task automatic drain();
        while (pixel_q.size() > 0 || pix.valid || hsi_expected_q.size() > 0)
            @(posedge i_clk);
    endtask

    initial begin
        pix.valid = 1'b0;
        pix.blue = '0;
        pix.green = '0;
        pix.red = '0;
        hsi.ready = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // corners, gray, black, green equals blue, hue close to a full turn
        push_pixel(0, 0, 0);
        push_pixel(255, 255, 255);
        push_pixel(128, 128, 128);
        push_pixel(0, 0, 255);
        push_pixel(0, 255, 0);
        push_pixel(255, 0, 0);
        push_pixel(255, 255, 0);
        push_pixel(0, 255, 255);
        push_pixel(255, 0, 255);
        push_pixel(100, 100, 20);
        push_pixel(100, 100, 200);
        push_pixel(1, 0, 255);
        push_pixel(2, 0, 255);
        push_pixel(0, 1, 255);
        push_pixel(1, 0, 0);
        push_pixel(0, 0, 1);
        push_pixel(170, 85, 85);
        push_pixel(85, 170, 85);
        push_pixel(254, 253, 255);
        push_pixel(170, 170, 85);
        drain();

        push_random(300);
        drain();
        send_idle_pct = 47;
        push_random(300);
        drain();
        send_idle_pct = 0;
        recv_stall_pct = 47;
        push_random(300);
        drain();
        send_idle_pct = 36;
        recv_stall_pct = 36;
        push_random(300);
        drain();

        // long output hold-off while requests keep coming
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 1'b1;
        push_random(300);
        drain();

        repeat (40) @(posedge i_clk);
        if (errors == 0 && hsi_expected_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
